// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the sensor display RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define SFSD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define SFSD_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ===== rtl/sfsd_pkg.sv =====
// Package: shared types, constants and code tables for the sensor display block
`timescale 1ns / 1ps

package sfsd_pkg;

   // Request classes
   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   // Classified request as it travels through the queue
   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } item_type;

   // Frame layout
   localparam logic [7:0] HEADER_FIRST  = 8'h42;
   localparam logic [7:0] HEADER_SECOND = 8'h4D;
   localparam int         HEADER_FIRST_POS  = 0;
   localparam int         HEADER_SECOND_POS = 1;
   localparam int         READ_HIGH_POS = 12;
   localparam int         READ_LOW_POS  = 13;

   // Decimal split: one divide by ten per cycle by reciprocal multiplication,
   // exact for every 16-bit value
   localparam int          BIN_W       = 16;
   localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
   localparam int          DIV10_SHIFT = 19;
   localparam int          CONV_STEPS  = 3;
   localparam int          STEP_W      = 2;
   localparam int          SHOWN       = 4;

   // Digit select pattern for each scan position
   function automatic logic [7:0] select_code(input logic [1:0] pos);
      logic [7:0] code;
      unique case (pos)
         2'd0: code = 8'h0F;
         2'd1: code = 8'hF7;
         2'd2: code = 8'hFB;
         2'd3: code = 8'hFD;
         default: code = 8'h0F;
      endcase
      return code;
   endfunction

   // Seven-segment code (gfedcba); anything above nine shows as nine
   function automatic logic [7:0] segment_code(input logic [3:0] digit);
      logic [7:0] code;
      unique case (digit)
         4'd0: code = 8'h3F;
         4'd1: code = 8'h06;
         4'd2: code = 8'h5B;
         4'd3: code = 8'h4F;
         4'd4: code = 8'h66;
         4'd5: code = 8'h6D;
         4'd6: code = 8'h7D;
         4'd7: code = 8'h27;
         4'd8: code = 8'h7F;
         default: code = 8'h67;
      endcase
      return code;
   endfunction

endpackage

// ===== rtl/sfsd_if.sv =====
// Channel interfaces: request (byte or tick) and response (display drive)
`timescale 1ns / 1ps

interface sfsd_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] rx_byte;

   modport source (output valid, output kind, output rx_byte, input ready);
   modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface sfsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] digit_select;
   logic [7:0] segment_drive;

   modport source (output valid, output digit_select, output segment_drive, input ready);
   modport sink   (input valid, input digit_select, input segment_drive, output ready);
endinterface

// ===== rtl/sfsd_front.sv =====
// Front end: accept requests, classify them and hold them in a two-entry queue
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfsd_front import sfsd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   sfsd_req_if.sink       req,
   output logic           q_valid,
   output item_type       q_item,
   input  logic           q_ready
);

   localparam int DEPTH = 2;

   item_type   entry_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;
   item_type   item_new;

   // Classify the incoming request
   always_comb begin
      item_new.op   = op_type'(req.kind);
      item_new.data = req.rx_byte;
   end

   assign req.ready = (count_ff != 2'(DEPTH));
   assign push      = req.valid && req.ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];
   assign pop       = q_valid && q_ready;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the request payload
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_new;
      end
   end

   `SFSD_ASSERT(a_fill_bounded, count_ff <= 2'(DEPTH), "queue fill count above depth")
   `SFSD_ASSERT(a_ptr_gap, (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff),
                "queue pointers disagree with fill count")

endmodule

// ===== rtl/sfsd_back.sv =====
// Back end: frame tracking, digit-per-cycle decimal split, display scan and output register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfsd_back import sfsd_pkg::*; #(
   parameter int FRAME_BYTES = 24
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   input  item_type       q_item,
   output logic           q_ready,
   sfsd_rsp_if.source     rsp
);

   localparam int POS_W = $clog2(FRAME_BYTES);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

   // Frame state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       first_ff, second_ff, high_ff, low_ff;
   logic [7:0]       low_eff;
   logic             frame_end;
   logic             frame_good;

   // Converter state
   logic               busy_ff, busy_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [BIN_W-1:0]   work_ff, work_in;
   logic [2*BIN_W-1:0] prod;
   logic [BIN_W-1:0]   quot;
   logic [BIN_W-1:0]   rem_full;
   logic [3:0]         rem_digit;
   logic               last_step;

   // Display state
   logic [3:0] shown_ff [SHOWN];
   logic [1:0] scan_ff, scan_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] select_ff, segment_ff;

   logic take;
   logic take_byte;
   logic take_tick;

   // Bytes always pass; ticks wait for a finished split and a free output register
   assign q_ready   = (q_item.op == OP_BYTE) || (!busy_ff && (!out_valid_ff || rsp.ready));
   assign take      = q_valid && q_ready;
   assign take_byte = take && (q_item.op == OP_BYTE);
   assign take_tick = take && (q_item.op == OP_TICK);

   // Frame end and header check
   always_comb begin
      frame_end  = (pos_ff == LAST_POS);
      low_eff    = (pos_ff == POS_W'(READ_LOW_POS)) ? q_item.data : low_ff;
      frame_good = (first_ff == HEADER_FIRST) && (second_ff == HEADER_SECOND);
      pos_in     = pos_ff;
      if (take_byte) begin
         pos_in = frame_end ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         first_ff  <= '0;
         second_ff <= '0;
         high_ff   <= '0;
         low_ff    <= '0;
      end else begin
         pos_ff <= pos_in;
         if (take_byte) begin
            if (pos_ff == POS_W'(HEADER_FIRST_POS))  first_ff  <= q_item.data;
            if (pos_ff == POS_W'(HEADER_SECOND_POS)) second_ff <= q_item.data;
            if (pos_ff == POS_W'(READ_HIGH_POS))     high_ff   <= q_item.data;
            if (pos_ff == POS_W'(READ_LOW_POS))      low_ff    <= q_item.data;
         end
      end
   end

   // Divide by ten each cycle: units, then tens, then hundreds; thousands is left over
   always_comb begin
      prod      = work_ff * DIV10_MUL;
      quot      = BIN_W'(prod >> DIV10_SHIFT);
      rem_full  = work_ff - {quot[BIN_W-4:0], 3'b000} - {quot[BIN_W-2:0], 1'b0};
      rem_digit = rem_full[3:0];
      last_step = (step_ff == STEP_W'(CONV_STEPS - 1));
      busy_in   = busy_ff;
      step_in   = step_ff;
      work_in   = work_ff;
      if (busy_ff) begin
         work_in = quot;
         step_in = step_ff + 1'b1;
         busy_in = !last_step;
      end else if (take_byte && frame_end && frame_good) begin
         work_in = {high_ff, low_eff};
         step_in = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      work_ff <= work_in;
   end

   // Load one shown digit per step; clamp thousands at nine on the last step
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SHOWN; i++) begin
            shown_ff[i] <= 4'd0;
         end
      end else if (busy_ff) begin
         shown_ff[2'(SHOWN - 1) - step_ff] <= rem_digit;
         if (last_step) begin
            shown_ff[0] <= (quot > BIN_W'(9)) ? 4'd9 : quot[3:0];
         end
      end
   end

   // Advance the scan and drop the response once taken
   always_comb begin
      scan_in      = take_tick ? scan_ff + 1'b1 : scan_ff;
      out_valid_in = out_valid_ff;
      if (take_tick) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         scan_ff      <= scan_in;
         out_valid_ff <= out_valid_in;
      end
      if (take_tick) begin
         select_ff  <= select_code(scan_in);
         segment_ff <= ~segment_code(shown_ff[scan_in]);
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.digit_select  = select_ff;
   assign rsp.segment_drive = segment_ff;

   `SFSD_NEVER(a_no_tick_busy, take_tick && busy_ff, "tick taken during conversion")
   `SFSD_ASSERT(a_conv_start, $rose(busy_ff) |-> (step_ff == '0),
                "conversion started at a nonzero step")
   `SFSD_ASSERT(a_rsp_from_tick, $rose(out_valid_ff) |-> $past(take_tick),
                "response raised without a tick request")
   `SFSD_ASSERT(a_digits_bounded, shown_ff[1] <= 4'd9 && shown_ff[2] <= 4'd9,
                "shown digit outside decimal range")

endmodule

// ===== rtl/sensor_frame_to_segment_display_top.sv =====
// Top level: particulate sensor frame decoder driving a multiplexed seven-segment display
//
//   channel   dir   handshake     payload
//   req_if    in    valid/ready   kind, rx_byte
//   rsp_if    out   valid/ready   digit_select, segment_drive
//
// One request is taken per cycle while the queue has room. A tick's response is held
// first in the queue, then in the output register.
// A frame end with a good header starts a decimal split that peels one digit per
// cycle; ticks wait behind it in the two-entry queue, bytes ahead of them flow on.
// A stalled response holds the next tick at the queue head; bytes ahead of it flow.
// Reset is synchronous and clears frame, digit, scan and queue state.
`timescale 1ns / 1ps

module sensor_frame_to_segment_display_top import sfsd_pkg::*; #(
   parameter int FRAME_BYTES = 24
) (
   input  logic         clock,
   input  logic         reset,
   sfsd_req_if.sink     req_if,
   sfsd_rsp_if.source   rsp_if
);

   logic     q_valid;
   logic     q_ready;
   item_type q_item;

   // Accept and queue requests
   sfsd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_ready (q_ready)
   );

   // Carry out bytes and ticks
   sfsd_back #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_ready (q_ready),
      .rsp     (rsp_if)
   );

endmodule

// ===== tb/sfsd_display_monitor.sv =====
// Display monitor: watches both channels, predicts the display drive and compares it
`timescale 1ns / 1ps

module sfsd_display_monitor import sfsd_pkg::*; #(
   parameter int FRAME_BYTES = 24
) (
   input  logic  clock,
   input  logic  reset,
   sfsd_req_if   req_if,
   sfsd_rsp_if   rsp_if,
   output int    mismatch_count,
   output int    outstanding
);

   typedef struct packed {
      logic [7:0] digit_select;
      logic [7:0] segment_drive;
   } drive_type;

   // Predicted decoder state
   logic [4:0] frame_pos;
   logic [7:0] hdr_first;
   logic [7:0] hdr_second;
   logic [7:0] level_high;
   logic [7:0] level_low;
   logic [3:0] digits [4];
   logic [1:0] scan_pos;

   // Display drives owed by the block, oldest first
   drive_type  owed_drive_q [$];

   // Select patterns per scan position and segment codes (gfedcba) per digit
   logic [7:0] select_rom  [4];
   logic [7:0] segment_rom [10];

   initial begin
      select_rom  = '{8'h0F, 8'hF7, 8'hFB, 8'hFD};
      segment_rom = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                      8'h6D, 8'h7D, 8'h27, 8'h7F, 8'h67};
   end

   // Split a reading into decimal digits; thousands saturate at nine
   function automatic void show_reading(input logic [15:0] level);
      int unsigned thousands;
      thousands = level / 1000;
      if (thousands > 9)
         thousands = 9;
      digits[0] = 4'(thousands);
      digits[1] = 4'((level / 100) % 10);
      digits[2] = 4'((level / 10) % 10);
      digits[3] = 4'(level % 10);
   endfunction

   // Store the bytes of interest and act on the frame end
   function automatic void take_sensor_byte(input logic [7:0] data);
      if (frame_pos == HEADER_FIRST_POS)
         hdr_first = data;
      else if (frame_pos == HEADER_SECOND_POS)
         hdr_second = data;
      else if (frame_pos == READ_HIGH_POS)
         level_high = data;
      else if (frame_pos == READ_LOW_POS)
         level_low = data;

      if (frame_pos >= FRAME_BYTES - 1) begin
         // A bad header leaves the digits as they were
         if (hdr_first == HEADER_FIRST && hdr_second == HEADER_SECOND)
            show_reading({level_high, level_low});
         frame_pos = '0;
      end else begin
         frame_pos = frame_pos + 5'd1;
      end
   endfunction

   // Advance the scan first, then show the new position
   function automatic drive_type scan_tick();
      drive_type  drive;
      logic [3:0] digit;
      scan_pos = scan_pos + 2'd1;
      digit = digits[scan_pos];
      if (digit > 4'd9)
         digit = 4'd9;
      drive.digit_select  = select_rom[scan_pos];
      drive.segment_drive = ~segment_rom[digit];
      return drive;
   endfunction

   always @(posedge clock) begin
      drive_type owed;
      if (reset) begin
         frame_pos      = '0;
         hdr_first      = '0;
         hdr_second     = '0;
         level_high     = '0;
         level_low      = '0;
         digits         = '{4'd0, 4'd0, 4'd0, 4'd0};
         scan_pos       = '0;
         owed_drive_q.delete();
         mismatch_count = 0;
      end else begin
         // Predict from each accepted request
         if (req_if.valid && req_if.ready) begin
            if (req_if.kind == OP_BYTE)
               take_sensor_byte(req_if.rx_byte);
            else
               owed_drive_q.push_back(scan_tick());
         end

         // Compare each accepted response with the oldest prediction
         if (rsp_if.valid && rsp_if.ready) begin
            if (owed_drive_q.size() == 0) begin
               $display("%0t: unexpected response: digit_select %02h segment_drive %02h",
                        $time, rsp_if.digit_select, rsp_if.segment_drive);
               mismatch_count++;
            end else begin
               owed = owed_drive_q.pop_front();
               if (rsp_if.digit_select !== owed.digit_select) begin
                  $display("%0t: digit_select mismatch: expected %02h actual %02h",
                           $time, owed.digit_select, rsp_if.digit_select);
                  mismatch_count++;
               end
               if (rsp_if.segment_drive !== owed.segment_drive) begin
                  $display("%0t: segment_drive mismatch: expected %02h actual %02h",
                           $time, owed.segment_drive, rsp_if.segment_drive);
                  mismatch_count++;
               end
            end
         end
      end
      outstanding = owed_drive_q.size();
   end

endmodule

// ===== tb/sensor_frame_to_segment_display_top_tb.sv =====
// Testbench top: drives sensor frames and scan ticks, stalls the display side, gives the verdict
`timescale 1ns / 1ps

module sensor_frame_to_segment_display_top_tb;
   import sfsd_pkg::*;

   localparam int FRAME_BYTES  = 24;
   localparam int ITEM_TARGET  = 1500;
   localparam int QUIET_ITEMS  = 300;
   localparam int PAUSE_AT     = 700;
   localparam int DRAIN_CYCLES = 40;
   // Slowest gap between handshakes is a conversion plus a display stall or a
   // sender gap; allow many times that
   localparam int IDLE_LIMIT   = 1000;

   logic clock;
   logic reset;

   sfsd_req_if req_if ();
   sfsd_rsp_if rsp_if ();

   int          mismatch_count;
   int          outstanding;
   int          sent_count;
   int          idle_cycles = 0;
   int          gap_percent;
   int          stall_percent;
   int          tick_percent;
   int          byte_pos;
   bit          quiet;
   bit          noise_on;
   logic [7:0]  plan_first;
   logic [7:0]  plan_second;
   logic [15:0] plan_level;

   sensor_frame_to_segment_display_top #(.FRAME_BYTES(FRAME_BYTES)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   sfsd_display_monitor #(.FRAME_BYTES(FRAME_BYTES)) u_display_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .rsp_if         (rsp_if),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Present one request at the falling edge and hold it until taken
   task automatic push_request(input op_type op, input logic [7:0] data);
      @(negedge clock);
      req_if.valid   <= 1'b1;
      req_if.kind    <= op;
      req_if.rx_byte <= data;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      sent_count++;
   endtask

   // Drop valid for a burst of idle cycles now and then
   task automatic maybe_idle_sender();
      int n;
      if (!quiet && $urandom_range(1, 100) <= gap_percent) begin
         n = $urandom_range(1, 12);
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Choose header and reading for the next frame
   task automatic plan_frame();
      int pick;
      case ($urandom_range(0, 3))
         0: plan_level = 16'($urandom_range(0, 9999));
         1: plan_level = 16'($urandom_range(10000, 65535));
         2: plan_level = 16'($urandom_range(1, 65) * 1000 + $urandom_range(0, 2) - 1);
         default: plan_level = 16'($urandom);
      endcase
      pick = $urandom_range(0, 99);
      plan_first  = HEADER_FIRST;
      plan_second = HEADER_SECOND;
      if (pick >= 96) begin
         plan_first  = HEADER_SECOND;
         plan_second = HEADER_FIRST;
      end else if (pick >= 88) begin
         plan_second = 8'($urandom);
      end else if (pick >= 80) begin
         plan_first = 8'($urandom);
      end
   endtask

   // Send the next byte of the planned frame, tracking its position
   task automatic send_frame_byte();
      logic [7:0] data;
      if (byte_pos == 0 && noise_on)
         plan_frame();
      if (byte_pos == HEADER_FIRST_POS)
         data = plan_first;
      else if (byte_pos == HEADER_SECOND_POS)
         data = plan_second;
      else if (byte_pos == READ_HIGH_POS)
         data = plan_level[15:8];
      else if (byte_pos == READ_LOW_POS)
         data = plan_level[7:0];
      else
         data = 8'($urandom);
      // Corrupt the odd byte, header and reading included
      if (noise_on && $urandom_range(0, 99) < 4)
         data = 8'($urandom);
      push_request(OP_BYTE, data);
      byte_pos = (byte_pos == FRAME_BYTES - 1) ? 0 : byte_pos + 1;
   endtask

   task automatic send_frame(input logic [7:0] first, input logic [7:0] second,
                             input logic [15:0] level);
      plan_first  = first;
      plan_second = second;
      plan_level  = level;
      repeat (FRAME_BYTES) send_frame_byte();
   endtask

   // Display side: stall ready in bursts at a randomly chosen stall rate
   initial begin
      int cycle;
      int n;
      cycle = 0;
      stall_percent = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         cycle++;
         if (cycle % 64 == 0)
            stall_percent = $urandom_range(0, 3) * 12;
         if (!quiet && !reset && $urandom_range(1, 100) <= stall_percent) begin
            n = $urandom_range(1, 12);
            rsp_if.ready <= 1'b0;
            repeat (n) @(negedge clock);
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when nothing is accepted for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus and verdict
   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.kind    = OP_BYTE;
      req_if.rx_byte = 8'h00;
      sent_count     = 0;
      byte_pos       = 0;
      quiet          = 1'b0;
      noise_on       = 1'b0;
      gap_percent    = 0;
      tick_percent   = 40;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Scan order from reset: positions 1, 2, 3, 0, 1 with all digits zero
      repeat (5) push_request(OP_TICK, 8'hFF);
      // Largest reading: thousands saturate, shows 9535
      send_frame(HEADER_FIRST, HEADER_SECOND, 16'hFFFF);
      repeat (4) push_request(OP_TICK, 8'h00);
      // Bad header: reading zero is dropped, digits hold
      send_frame(8'h00, HEADER_SECOND, 16'h0000);
      repeat (4) push_request(OP_TICK, 8'h5A);

      // Random frames with ticks mixed in
      noise_on = 1'b1;
      while (sent_count < ITEM_TARGET) begin
         if (sent_count == PAUSE_AT) begin
            // Hold off until every owed drive has come out
            @(negedge clock);
            req_if.valid <= 1'b0;
            while (outstanding != 0)
               @(negedge clock);
         end
         if (sent_count >= ITEM_TARGET - QUIET_ITEMS)
            quiet = 1'b1;
         if (sent_count % 48 == 0) begin
            gap_percent  = $urandom_range(0, 3) * 12;
            tick_percent = $urandom_range(15, 60);
         end
         maybe_idle_sender();
         if ($urandom_range(0, 99) < tick_percent)
            push_request(OP_TICK, 8'($urandom));
         else
            send_frame_byte();
      end

      // Drain and let the block settle
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && outstanding == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
